FILE: sv/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

   localparam int SYM_W       = 8;
   localparam int CODE_W      = 19;
   localparam int LEN_W       = 5;
   localparam int BYTE_W      = 8;
   localparam int ENTRY_W     = CODE_W + LEN_W;
   localparam int ACC_W       = BYTE_W - 1 + CODE_W;
   localparam int TOT_W       = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_ENCODE = 1'b1
   } kind_type;

   // One encode job: code bits already reversed so the first bit sits in bit 0.
   typedef struct packed {
      logic              term;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } item_slot_type;

endpackage

FILE: sv/hcbp_if.sv
// Request and response channel interfaces of the Huffman code bit packer.
interface hcbp_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [hcbp_pkg::SYM_W-1:0]  symbol;
   logic [hcbp_pkg::CODE_W-1:0] code_bits;
   logic [hcbp_pkg::LEN_W-1:0]  code_length;

   modport source (output valid, kind, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, kind, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hcbp_pkg::BYTE_W-1:0] out_byte;
   logic                        run_end;
   logic                        message_end;

   modport source (output valid, out_byte, run_end, message_end, input ready);
   modport sink   (input valid, out_byte, run_end, message_end, output ready);
endinterface

FILE: sv/hcbp_front.sv
// Front end: accepts requests, owns the code table and queues encode jobs.
module hcbp_front #(
   parameter int MAX_CODE_LEN = 19,
   parameter int NUM_SYMBOLS  = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [hcbp_pkg::SYM_W-1:0]      req_symbol,
   input  logic [hcbp_pkg::CODE_W-1:0]     req_code_bits,
   input  logic [hcbp_pkg::LEN_W-1:0]      req_code_length,
   input  logic [hcbp_pkg::QCNT_W-1:0]     queue_count,
   output hcbp_pkg::item_slot_type         push
);

   localparam int ADDR_W    = $clog2(NUM_SYMBOLS);
   localparam int LEN_LIMIT = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hcbp_pkg::CODE_W;

   logic [hcbp_pkg::ENTRY_W-1:0] table_mem [NUM_SYMBOLS];
   logic [hcbp_pkg::ENTRY_W-1:0] rd_ff;
   logic                         s1_valid_ff;
   logic                         s1_term_ff;
   logic                         s1_in_range_ff;

   logic                         accept;
   logic                         in_range;
   logic [ADDR_W-1:0]            addr;
   logic [hcbp_pkg::LEN_W-1:0]   len_sat;
   logic [hcbp_pkg::LEN_W-1:0]   rd_len;
   logic [hcbp_pkg::CODE_W-1:0]  rd_code;
   logic [hcbp_pkg::CODE_W-1:0]  rev_code;

   // Room is counted against the queue plus the job in the table read stage.
   assign req_ready = (queue_count + hcbp_pkg::QCNT_W'(s1_valid_ff))
                      < hcbp_pkg::QCNT_W'(hcbp_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign in_range  = {1'b0, req_symbol} < (hcbp_pkg::SYM_W + 1)'(NUM_SYMBOLS);
   assign addr      = req_symbol[ADDR_W-1:0];
   assign len_sat   = (req_code_length > hcbp_pkg::LEN_W'(LEN_LIMIT))
                      ? hcbp_pkg::LEN_W'(LEN_LIMIT) : req_code_length;

   always_ff @(posedge clock) begin
      if (accept && (req_kind == hcbp_pkg::KIND_LOAD) && in_range) begin
         table_mem[addr] <= {len_sat, req_code_bits};
      end
      if (accept && (req_kind == hcbp_pkg::KIND_ENCODE)) begin
         rd_ff <= table_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && (req_kind == hcbp_pkg::KIND_ENCODE);
      end
      if (accept) begin
         s1_term_ff     <= (req_symbol == '0);
         s1_in_range_ff <= in_range;
      end
   end

   // Reverse the code so its most significant valid bit lands in bit 0.
   always_comb begin
      rd_code = rd_ff[hcbp_pkg::CODE_W-1:0];
      rd_len  = s1_in_range_ff ? rd_ff[hcbp_pkg::ENTRY_W-1:hcbp_pkg::CODE_W] : '0;
      for (int i = 0; i < hcbp_pkg::CODE_W; i++) begin
         rev_code[i] = rd_code[hcbp_pkg::CODE_W-1-i];
      end
      push.valid     = s1_valid_ff;
      push.item.term = s1_term_ff;
      push.item.len  = rd_len;
      push.item.bits = rev_code >> (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - rd_len);
   end

endmodule

FILE: sv/hcbp_queue.sv
// Short job queue between the front end and the bit packer.
module hcbp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  hcbp_pkg::item_slot_type      push,
   input  logic                         pop,
   output hcbp_pkg::item_slot_type      head,
   output logic [hcbp_pkg::QCNT_W-1:0]  count
);

   hcbp_pkg::item_type                q_ff [hcbp_pkg::QUEUE_DEPTH];
   logic [hcbp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hcbp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hcbp_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + hcbp_pkg::QCNT_W'(push.valid) - hcbp_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.valid) begin
         q_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

FILE: sv/hcbp_back.sv
// Bit packer: merges code bits into bytes and drives the response register.
module hcbp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  hcbp_pkg::item_slot_type      head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hcbp_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_run_end,
   output logic                         rsp_message_end
);

   logic [hcbp_pkg::BYTE_W-1:0]   pack_byte_ff, pack_byte_in;
   logic [2:0]                    pack_count_ff, pack_count_in;
   logic                          busy_ff, busy_in;
   logic [hcbp_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [hcbp_pkg::TOT_W-1:0]    total_ff, total_in;
   logic                          term_ff, term_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hcbp_pkg::BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                          run_end_ff, run_end_in;
   logic                          msg_end_ff, msg_end_in;

   logic                          src_valid;
   logic [hcbp_pkg::ACC_W-1:0]    src_acc;
   logic [hcbp_pkg::TOT_W-1:0]    src_total;
   logic                          src_term;
   logic                          full;
   logic                          emit;
   logic                          can_out;
   logic                          advance;
   logic [hcbp_pkg::ACC_W-1:0]    rem_acc;
   logic [hcbp_pkg::TOT_W-1:0]    rem_total;
   logic                          last;

   always_comb begin
      // A job in progress has priority; otherwise the queue head merges with the pack.
      src_valid = busy_ff || head.valid;
      if (busy_ff) begin
         src_acc   = acc_ff;
         src_total = total_ff;
         src_term  = term_ff;
      end else begin
         src_acc   = (hcbp_pkg::ACC_W'(head.item.bits) << pack_count_ff)
                     | hcbp_pkg::ACC_W'(pack_byte_ff);
         src_total = hcbp_pkg::TOT_W'(pack_count_ff) + hcbp_pkg::TOT_W'(head.item.len);
         src_term  = head.item.term;
      end

      full      = src_total >= hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W);
      emit      = src_valid && (full || (src_term && (src_total != '0)));
      can_out   = !rsp_valid_ff || rsp_ready;
      advance   = src_valid && (!emit || can_out);
      pop       = advance && !busy_ff;
      rem_acc   = src_acc >> hcbp_pkg::BYTE_W;
      rem_total = full ? src_total - hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W) : '0;
      last      = (rem_total < hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W))
                  && !(src_term && (rem_total != '0));

      pack_byte_in  = pack_byte_ff;
      pack_count_in = pack_count_ff;
      busy_in       = busy_ff;
      acc_in        = acc_ff;
      total_in      = total_ff;
      term_in       = term_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      run_end_in    = run_end_ff;
      msg_end_in    = msg_end_ff;

      if (advance) begin
         if (emit) begin
            rsp_valid_in = 1'b1;
            out_byte_in  = src_acc[hcbp_pkg::BYTE_W-1:0];
            run_end_in   = last;
            msg_end_in   = last && src_term;
            if (last) begin
               busy_in       = 1'b0;
               pack_byte_in  = src_term ? '0 : rem_acc[hcbp_pkg::BYTE_W-1:0];
               pack_count_in = src_term ? '0 : rem_total[2:0];
            end else begin
               busy_in  = 1'b1;
               acc_in   = rem_acc;
               total_in = rem_total;
               term_in  = src_term;
            end
         end else begin
            pack_byte_in  = src_term ? '0 : src_acc[hcbp_pkg::BYTE_W-1:0];
            pack_count_in = src_term ? '0 : src_total[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_byte_ff  <= '0;
         pack_count_ff <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pack_byte_ff  <= pack_byte_in;
         pack_count_ff <= pack_count_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      total_ff    <= total_in;
      term_ff     <= term_in;
      out_byte_ff <= out_byte_in;
      run_end_ff  <= run_end_in;
      msg_end_ff  <= msg_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_end     = run_end_ff;
   assign rsp_message_end = msg_end_ff;

endmodule

FILE: sv/huffman_code_bit_packer_top.sv
// Top level of the table-driven Huffman code bit packer.
//
// The block takes one request per cycle while the queue has room. A load request
// writes one entry of the code table and produces no response; an encode request
// reads its entry from the table, passes through a four-entry job queue and is
// merged into the pending output byte by the bit packer. The packer emits at most
// one response byte per cycle, and an encode request completes from 0 to 4 bytes;
// this single byte-wide output path is what sets the sustained rate, and the queue
// lets requests keep arriving while a long code spills several bytes. An encode
// request reaches its first byte through the table read register, the queue and
// the response register. The code table has no reset and no clearing pass, so a
// symbol must be loaded before it is encoded. A zero symbol is encoded like any
// other, then flushes a partial byte and marks the last response of the message.
module huffman_code_bit_packer_top #(
   parameter int MAX_CODE_LEN = 19,
   parameter int NUM_SYMBOLS  = 256
) (
   input  logic       clock,
   input  logic       reset,
   hcbp_req_if.sink   req_chan,
   hcbp_rsp_if.source rsp_chan
);

   // Front end to queue, and queue head to packer, travel as slot structs.
   hcbp_pkg::item_slot_type            push;
   hcbp_pkg::item_slot_type            head;
   logic [hcbp_pkg::QCNT_W-1:0]        queue_count;
   logic                               pop;

   hcbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .NUM_SYMBOLS  (NUM_SYMBOLS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_kind        (req_chan.kind),
      .req_symbol      (req_chan.symbol),
      .req_code_bits   (req_chan.code_bits),
      .req_code_length (req_chan.code_length),
      .queue_count     (queue_count),
      .push            (push)
   );

   hcbp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (queue_count)
   );

   // The packer holds the partial byte and a registered response stage, so a
   // stalled consumer never blocks the front end until the queue fills.
   hcbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_run_end     (rsp_chan.run_end),
      .rsp_message_end (rsp_chan.message_end)
   );

endmodule

FILE: sv/hcbp_checker.sv
// Port-level checks of the Huffman code bit packer and their binding.
module hcbp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [hcbp_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                        rsp_run_end,
   input logic                        rsp_message_end
);

   // The end of a message is always the end of the request that caused it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_run_end)
      else $error("message_end without run_end");

   // Reset leaves no response pending and the request side open.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // A stalled response keeps its byte and flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_end) && $stable(rsp_message_end))
      else $error("stalled response changed");

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_run_end     (rsp_chan.run_end),
   .rsp_message_end (rsp_chan.message_end)
);
